/* src/scp_pkg.sv */
// ============================================================================
// scp_pkg
// Shared widths, fixed-point constants and helpers of the sine/cosine unit.
// ============================================================================
package scp_pkg;

    // Operation codes.
    localparam logic OP_SIN = 1'b0;
    localparam logic OP_COS = 1'b1;

    // Field widths.
    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 18;

    // Pipeline layout.
    localparam int RED_STAGES  = 5;
    localparam int POLY_STAGES = 5;
    localparam int NUM_STAGES  = RED_STAGES + POLY_STAGES + 1;

    // Internal widths of the reduction stages.
    localparam int U1_W = 33;
    localparam int U2_W = 31;
    localparam int U3_W = 29;
    localparam int U4_W = 27;
    localparam int X_W  = 25;

    // Internal widths of the polynomial stages.
    localparam int X2_W = 32;
    localparam int T1_W = 24;
    localparam int T2_W = 28;
    localparam int T3_W = 31;
    localparam int Y_W  = 31;
    localparam int MAG_W = 17;
    localparam int Q_SHIFT = 6;

    // Angle constants in Q8.24, rounded to nearest.
    localparam logic [32:0] HALF_PI_Q24 = 33'd26353589;
    localparam logic [32:0] PI_Q24      = 33'd52707179;
    localparam logic [32:0] TWO_PI_Q24  = 33'd105414357;

    // Multiples of two pi used by the restoring reduction.
    localparam logic [32:0] TWO_PI_X32 = TWO_PI_Q24 << 5;
    localparam logic [32:0] TWO_PI_X16 = TWO_PI_Q24 << 4;
    localparam logic [32:0] TWO_PI_X8  = TWO_PI_Q24 << 3;
    localparam logic [32:0] TWO_PI_X4  = TWO_PI_Q24 << 2;
    localparam logic [32:0] TWO_PI_X2  = TWO_PI_Q24 << 1;

    // Bias of 21 full turns makes every angle non-negative before reduction.
    localparam logic [32:0] OFS_SIN = 33'd2213701497;
    localparam logic [32:0] OFS_COS = OFS_SIN + HALF_PI_Q24;

    // Polynomial coefficients in unsigned Q30.
    localparam logic [31:0] ONE_Q30       = 32'd1073741824;
    localparam logic [31:0] INV_FACT3_Q30 = 32'd178956971;
    localparam logic [31:0] INV_FACT5_Q30 = 32'd8947849;
    localparam logic [31:0] INV_FACT7_Q30 = 32'd213044;

    // Final rounding from Q30 to Q16.
    localparam logic [31:0] Q16_ROUND = 32'd8192;
    localparam int          Q16_SHIFT = 14;

    // Subtracts d from v when v is not below d.
    function automatic logic [32:0] cond_sub(input logic [32:0] v, input logic [32:0] d);
        cond_sub = (v >= d) ? (v - d) : v;
    endfunction

    // Q30 product, rounded half up.
    function automatic logic [33:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        mul_q30 = 34'((p + (64'd1 << 29)) >> 30);
    endfunction

endpackage

/* src/scp_ifs.sv */
// ============================================================================
// scp_in_if / scp_out_if
// Valid/ready channels carrying angle items in and result items out.
// ============================================================================
interface scp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic signed [scp_pkg::ANGLE_W-1:0]   angle;

    modport source (output valid, output opcode, output angle, input ready);
    modport sink   (input valid, input opcode, input angle, output ready);
endinterface

interface scp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [scp_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* src/scp_reduce.sv */
// ============================================================================
// scp_reduce
// Range reduction modulo two pi and folding into the first quadrant.
// ============================================================================
module scp_reduce (
    input  logic                                   i_clk,
    input  logic [scp_pkg::RED_STAGES-1:0]         i_en,
    input  logic                                   i_opcode,
    input  logic signed [scp_pkg::ANGLE_W-1:0]     i_angle,
    output logic [scp_pkg::X_W-1:0]                o_x,
    output logic                                   o_neg
);

    logic [scp_pkg::U1_W-1:0] r_u1, n_u1;
    logic [scp_pkg::U2_W-1:0] r_u2, n_u2;
    logic [scp_pkg::U3_W-1:0] r_u3, n_u3;
    logic [scp_pkg::U4_W-1:0] r_u4, n_u4;
    logic [scp_pkg::X_W-1:0]  r_x,  n_x;
    logic                     r_neg, n_neg;
    logic [32:0]              fold_m;

    // The biased sum is non-negative and below 42 turns, so six restoring
    // steps leave the floored remainder.
    always_comb begin
        n_u1 = {i_angle[scp_pkg::ANGLE_W-1], i_angle}
             + ((i_opcode == scp_pkg::OP_COS) ? scp_pkg::OFS_COS : scp_pkg::OFS_SIN);
        n_u2 = scp_pkg::U2_W'(scp_pkg::cond_sub(
                   scp_pkg::cond_sub(r_u1, scp_pkg::TWO_PI_X32), scp_pkg::TWO_PI_X16));
        n_u3 = scp_pkg::U3_W'(scp_pkg::cond_sub(
                   scp_pkg::cond_sub(33'(r_u2), scp_pkg::TWO_PI_X8), scp_pkg::TWO_PI_X4));
        n_u4 = scp_pkg::U4_W'(scp_pkg::cond_sub(
                   scp_pkg::cond_sub(33'(r_u3), scp_pkg::TWO_PI_X2), scp_pkg::TWO_PI_Q24));
        // Lower half-turn is taken as is; the upper one negates the result.
        n_neg  = (33'(r_u4) >= scp_pkg::PI_Q24);
        fold_m = scp_pkg::cond_sub(33'(r_u4), scp_pkg::PI_Q24);
        n_x    = scp_pkg::X_W'((fold_m > scp_pkg::HALF_PI_Q24) ?
                               (scp_pkg::PI_Q24 - fold_m) : fold_m);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_u1 <= n_u1;
        end
        if (i_en[1]) begin
            r_u2 <= n_u2;
        end
        if (i_en[2]) begin
            r_u3 <= n_u3;
        end
        if (i_en[3]) begin
            r_u4 <= n_u4;
        end
        if (i_en[4]) begin
            r_x   <= n_x;
            r_neg <= n_neg;
        end
    end

    assign o_x   = r_x;
    assign o_neg = r_neg;

endmodule

/* src/scp_poly.sv */
// ============================================================================
// scp_poly
// Horner evaluation of the seventh-order sine polynomial, one product a stage.
// ============================================================================
module scp_poly (
    input  logic                              i_clk,
    input  logic [scp_pkg::POLY_STAGES-1:0]   i_en,
    input  logic [scp_pkg::X_W-1:0]           i_x,
    input  logic                              i_neg,
    output logic [scp_pkg::Y_W-1:0]           o_y,
    output logic                              o_neg
);

    logic [scp_pkg::X_W-1:0]  r_x6, r_x7, r_x8, r_x9;
    logic                     r_neg6, r_neg7, r_neg8, r_neg9, r_neg10;
    logic [scp_pkg::X2_W-1:0] r_x2_6, r_x2_7, r_x2_8, n_x2;
    logic [scp_pkg::T1_W-1:0] r_t1, n_t1;
    logic [scp_pkg::T2_W-1:0] r_t2, n_t2;
    logic [scp_pkg::T3_W-1:0] r_t3, n_t3;
    logic [scp_pkg::Y_W-1:0]  r_y, n_y;
    logic [31:0]              x_in_q30, x_out_q30;

    // Every intermediate stays non-negative on the first quadrant.
    always_comb begin
        x_in_q30  = 32'({i_x, {scp_pkg::Q_SHIFT{1'b0}}});
        x_out_q30 = 32'({r_x9, {scp_pkg::Q_SHIFT{1'b0}}});
        n_x2 = scp_pkg::X2_W'(scp_pkg::mul_q30(x_in_q30, x_in_q30));
        n_t1 = scp_pkg::T1_W'(34'(scp_pkg::INV_FACT5_Q30)
               - scp_pkg::mul_q30(r_x2_6, scp_pkg::INV_FACT7_Q30));
        n_t2 = scp_pkg::T2_W'(34'(scp_pkg::INV_FACT3_Q30)
               - scp_pkg::mul_q30(r_x2_7, 32'(r_t1)));
        n_t3 = scp_pkg::T3_W'(34'(scp_pkg::ONE_Q30)
               - scp_pkg::mul_q30(r_x2_8, 32'(r_t2)));
        n_y  = scp_pkg::Y_W'(scp_pkg::mul_q30(x_out_q30, 32'(r_t3)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x2_6 <= n_x2;
            r_x6   <= i_x;
            r_neg6 <= i_neg;
        end
        if (i_en[1]) begin
            r_t1   <= n_t1;
            r_x2_7 <= r_x2_6;
            r_x7   <= r_x6;
            r_neg7 <= r_neg6;
        end
        if (i_en[2]) begin
            r_t2   <= n_t2;
            r_x2_8 <= r_x2_7;
            r_x8   <= r_x7;
            r_neg8 <= r_neg7;
        end
        if (i_en[3]) begin
            r_t3   <= n_t3;
            r_x9   <= r_x8;
            r_neg9 <= r_neg8;
        end
        if (i_en[4]) begin
            r_y     <= n_y;
            r_neg10 <= r_neg9;
        end
    end

    assign o_y   = r_y;
    assign o_neg = r_neg10;

endmodule

/* src/sine_cosine_polynomial.sv */
// ============================================================================
// sine_cosine_polynomial
// Pipelined sine/cosine of a Q8.24 angle by polynomial, result in Q1.16.
// ============================================================================
// An accepted item passes the reduction stages, the polynomial stages and the
// output register; with the output ready the result leaves at the next edge.
// Throughput: one item per cycle until a stalled output fills the eleven-stage
// pipeline; slowest are the polynomial stages, each with one 32x32 multiplier.
// Stalls collapse bubbles: a stage takes new data whenever it or a later
// stage has room, so items keep entering while a result waits at the output.
// Reset (synchronous, active low) clears every stage valid bit; data is kept.
module sine_cosine_polynomial (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scp_in_if.sink       i_in,
    scp_out_if.source    o_out
);

    localparam logic [scp_pkg::NUM_STAGES-1:0] ALL_VALID = '1;

    // One valid bit per pipeline register; bit 0 is the first stage and the
    // top bit is the output register.
    logic [scp_pkg::NUM_STAGES-1:0] r_vld, n_vld;
    logic [scp_pkg::NUM_STAGES-1:0] stage_en;
    logic [scp_pkg::NUM_STAGES-1:0] vld_src;

    logic [scp_pkg::X_W-1:0]        red_x;
    logic                           red_neg;
    logic [scp_pkg::Y_W-1:0]        poly_y;
    logic                           poly_neg;

    logic [scp_pkg::Y_W-1:0]        y_clamped;
    logic [scp_pkg::MAG_W-1:0]      mag;
    logic signed [scp_pkg::VALUE_W-1:0] r_value, n_value;

    // A stage may load when it is empty or when some later stage is empty,
    // or when the output is being taken: the whole tail then moves by one.
    always_comb begin
        for (int k = 0; k < scp_pkg::NUM_STAGES; k++) begin
            stage_en[k] = o_out.ready || ((r_vld >> k) != (ALL_VALID >> k));
        end
        vld_src = {r_vld[scp_pkg::NUM_STAGES-2:0], i_in.valid};
        n_vld   = (stage_en & vld_src) | (~stage_en & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Reduction and folding: stages one to five.
    scp_reduce u_reduce (
        .i_clk    (i_clk),
        .i_en     (stage_en[scp_pkg::RED_STAGES-1:0]),
        .i_opcode (i_in.opcode),
        .i_angle  (i_in.angle),
        .o_x      (red_x),
        .o_neg    (red_neg)
    );

    // Polynomial: stages six to ten.
    scp_poly u_poly (
        .i_clk  (i_clk),
        .i_en   (stage_en[scp_pkg::NUM_STAGES-2:scp_pkg::RED_STAGES]),
        .i_x    (red_x),
        .i_neg  (red_neg),
        .o_y    (poly_y),
        .o_neg  (poly_neg)
    );

    // Output stage: clamp to one, round to Q16 and apply the tracked sign.
    // A zero magnitude with the sign set still gives zero.
    always_comb begin
        y_clamped = (poly_y > scp_pkg::Y_W'(scp_pkg::ONE_Q30)) ?
                    scp_pkg::Y_W'(scp_pkg::ONE_Q30) : poly_y;
        mag       = scp_pkg::MAG_W'((32'(y_clamped) + scp_pkg::Q16_ROUND)
                                    >> scp_pkg::Q16_SHIFT);
        n_value   = poly_neg ? (scp_pkg::VALUE_W'(0) - scp_pkg::VALUE_W'(mag))
                             : scp_pkg::VALUE_W'(mag);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[scp_pkg::NUM_STAGES-1]) begin
            r_value <= n_value;
        end
    end

    assign i_in.ready  = stage_en[0];
    assign o_out.valid = r_vld[scp_pkg::NUM_STAGES-1];
    assign o_out.value = r_value;

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    // An accepted item always lands in the first stage.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted item lost at first stage");

    // A full pipeline with a stalled output takes no new item.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_vld) == scp_pkg::NUM_STAGES && !o_out.ready) |-> !i_in.ready)
        else $error("item accepted into a full pipeline");

    // Results never leave the closed range of minus one to one.
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.value <= 18'sd65536 && o_out.value >= -18'sd65536))
        else $error("result outside of unit range");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the pipelined sine/cosine unit. A bit-exact
// fixed-point predictor works out the Q1.16 value of every accepted angle
// item. Each result leaving the block is compared, in order, against it.
// ============================================================================
module tb;

    // Q8.24 angle constants and Q30 coefficients of the predictor.
    localparam longint RAD_HALF_PI = 64'sd26353589;
    localparam longint RAD_PI      = 64'sd52707179;
    localparam longint RAD_TWO_PI  = 64'sd105414357;
    localparam longint unsigned UNITY_Q30 = 64'd1073741824;
    localparam longint unsigned RECIP3_Q30 = 64'd178956971;
    localparam longint unsigned RECIP5_Q30 = 64'd8947849;
    localparam longint unsigned RECIP7_Q30 = 64'd213044;

    // Eleven pipeline stages, so a short tail covers any late result.
    localparam int DRAIN_CYCLES = 40;
    // Cycles without a single handshake before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1200;

    // Holds the values still owed by the block, oldest first, and
    // compares every result against the head of that queue.
    class angle_scoreboard;
        logic signed [scp_pkg::VALUE_W-1:0] pending_values[$];
        int                                 mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Q30 product, rounded half up.
        function longint unsigned q30_product(longint unsigned a, longint unsigned b);
            return (a * b + (64'd1 << 29)) >> 30;
        endfunction

        // Odd seventh-order series for sin() on a first-quadrant angle (Q24).
        function longint unsigned quadrant_sine_q16(longint unsigned x_q24);
            longint unsigned x, x_sq, inner, middle, outer, y;
            x      = x_q24 << 6;
            x_sq   = q30_product(x, x);
            inner  = RECIP5_Q30 - q30_product(x_sq, RECIP7_Q30);
            middle = RECIP3_Q30 - q30_product(x_sq, inner);
            outer  = UNITY_Q30 - q30_product(x_sq, middle);
            y      = q30_product(x, outer);
            if (y > UNITY_Q30) begin
                y = UNITY_Q30;
            end
            return (y + (64'd1 << 13)) >> 14;
        endfunction

        // Full sine/cosine value of one angle item, in Q1.16.
        function logic signed [scp_pkg::VALUE_W-1:0] sin_cos_q16(
                logic op, logic signed [scp_pkg::ANGLE_W-1:0] angle);
            longint          phase;
            bit              negate;
            longint unsigned magnitude;
            phase = longint'(angle);
            if (op == scp_pkg::OP_COS) begin
                phase += RAD_HALF_PI;
            end
            // Floored remainder: negative angles land in [0, 2*pi) too.
            phase = phase % RAD_TWO_PI;
            if (phase < 0) begin
                phase += RAD_TWO_PI;
            end
            negate = 1'b0;
            if (phase >= RAD_PI) begin
                negate = 1'b1;
                phase -= RAD_PI;
            end
            if (phase > RAD_HALF_PI) begin
                phase = RAD_PI - phase;
            end
            if (phase < 0) begin
                phase = 0;
            end
            magnitude = quadrant_sine_q16(longint'(phase));
            // A zero magnitude with the sign set stays plain zero.
            if (negate) begin
                return scp_pkg::VALUE_W'(-magnitude);
            end
            return scp_pkg::VALUE_W'(magnitude);
        endfunction

        function void note_angle(logic op, logic signed [scp_pkg::ANGLE_W-1:0] angle);
            pending_values.push_back(sin_cos_q16(op, angle));
        endfunction

        function void check_value(logic signed [scp_pkg::VALUE_W-1:0] got);
            logic signed [scp_pkg::VALUE_W-1:0] want;
            if (pending_values.size() == 0) begin
                $error("value: unexpected result %0d with nothing outstanding", got);
                mismatch_count++;
                return;
            end
            want = pending_values.pop_front();
            if (got !== want) begin
                $error("value mismatch: expected %0d, actual %0d", want, got);
                mismatch_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    scp_in_if  u_in_if ();
    scp_out_if u_out_if ();

    sine_cosine_polynomial u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    angle_scoreboard sb = new();

    // While set, neither the sender nor the receiver pauses.
    bit no_pause;
    int idle_cycles;

    // Every input starts at a known value before the first edge.
    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        no_pause        = 1'b0;
        u_in_if.valid   = 1'b0;
        u_in_if.opcode  = scp_pkg::OP_SIN;
        u_in_if.angle   = '0;
        u_out_if.ready  = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // The receiver holds off about 23 times in a hundred, except
    // inside the steady window, where results drain at full rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_out_if.ready <= 1'b0;
        end else begin
            u_out_if.ready <= no_pause || ($urandom_range(99) >= 23);
        end
    end

    // Monitors run on the values held just before each edge, so both the
    // block's registers and the drivers above have not moved yet.
    always @(posedge i_clk) begin
        if (i_rst_n && u_in_if.valid && u_in_if.ready) begin
            sb.note_angle(u_in_if.opcode, u_in_if.angle);
        end
        if (i_rst_n && u_out_if.valid && u_out_if.ready) begin
            sb.check_value(u_out_if.value);
        end
    end

    // Hang detector: any handshake on either side resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (u_in_if.valid && u_in_if.ready)
                || (u_out_if.valid && u_out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one angle item and returns once the block has taken it. Gaps
    // are drawn before the item, so they can fall on any pipeline phase.
    task automatic send_angle(logic op, logic signed [scp_pkg::ANGLE_W-1:0] angle);
        while (!no_pause && $urandom_range(99) < 23) begin
            u_in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_in_if.valid  <= 1'b1;
        u_in_if.opcode <= op;
        u_in_if.angle  <= angle;
        do begin
            @(posedge i_clk);
        end while (!(u_in_if.valid && u_in_if.ready));
    endtask

    // Edge angles, each sent as a sine and as a cosine: field extremes,
    // the quadrant boundaries and their neighbors, and pi itself, where
    // the fold ends at zero with the sign flipped.
    task automatic run_directed();
        longint corner[12];
        corner = '{0, 1, -1, 64'sh7FFFFFFF, -64'sh80000000,
                   RAD_HALF_PI, RAD_HALF_PI + 1, RAD_PI - 1, RAD_PI,
                   -RAD_HALF_PI, RAD_TWO_PI, -RAD_TWO_PI - 1};
        foreach (corner[i]) begin
            send_angle(scp_pkg::OP_SIN, scp_pkg::ANGLE_W'(corner[i]));
            send_angle(scp_pkg::OP_COS, scp_pkg::ANGLE_W'(corner[i]));
        end
    endtask

    // Random angles in three flavors: anywhere in the 32-bit range, close
    // to a multiple of pi/2 where the folding decisions flip, and within
    // one turn either side of zero.
    task automatic run_random();
        logic   op;
        longint phase;
        int     flavor;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_pause = (n >= 500) && (n < 700);
            op       = $urandom_range(1) ? scp_pkg::OP_COS : scp_pkg::OP_SIN;
            flavor   = $urandom_range(9);
            if (flavor < 4) begin
                phase = longint'($signed(32'($urandom)));
            end else if (flavor < 7) begin
                phase = RAD_HALF_PI * ($signed($urandom_range(160)) - 80)
                        + $signed($urandom_range(8192)) - 4096;
            end else begin
                phase = $signed($urandom_range(2 * 105414357)) - RAD_TWO_PI;
            end
            send_angle(op, scp_pkg::ANGLE_W'(phase));
        end
        no_pause = 1'b0;
        u_in_if.valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random();

        // Let every outstanding result come out, then watch a short tail
        // for anything the block sends on its own.
        while (sb.pending_values.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
src/scp_pkg.sv
src/scp_ifs.sv
src/scp_reduce.sv
src/scp_poly.sv
src/sine_cosine_polynomial.sv
test/tb.sv
